// File: hw/rtl/ckp_pkg.sv
package ckp_pkg;

   // Field widths
   localparam int ByteW     = 8;
   localparam int QueryW    = 22;
   localparam int CanonOutW = 22;
   localparam int MaskW     = 4;
   localparam int CountW    = 3;
   localparam int ClassW    = 3;
   localparam int GcW       = 5;
   localparam int MaxKmerW  = 32;

   // Presence bitmap geometry
   localparam int WordW     = 64;
   localparam int BitSelW   = 6;
   localparam int WordAddrW = 16;
   localparam int Words     = 65536;

   // Request modes
   localparam logic ModeIngest = 1'b0;
   localparam logic ModeQuery  = 1'b1;

   // Characters
   localparam logic [ByteW-1:0] ChLf     = 8'd10;
   localparam logic [ByteW-1:0] ChCr     = 8'd13;
   localparam logic [ByteW-1:0] ChSpace  = 8'd32;
   localparam logic [ByteW-1:0] ChTab    = 8'd9;
   localparam logic [ByteW-1:0] ChHeader = 8'h3E;
   localparam logic [ByteW-1:0] ChUpA    = 8'h41;
   localparam logic [ByteW-1:0] ChUpC    = 8'h43;
   localparam logic [ByteW-1:0] ChUpG    = 8'h47;
   localparam logic [ByteW-1:0] ChUpT    = 8'h54;
   localparam logic [ByteW-1:0] ChLoA    = 8'h61;
   localparam logic [ByteW-1:0] ChLoC    = 8'h63;
   localparam logic [ByteW-1:0] ChLoG    = 8'h67;
   localparam logic [ByteW-1:0] ChLoT    = 8'h74;

   // Base codes
   localparam logic [1:0] BaseA = 2'd0;
   localparam logic [1:0] BaseC = 2'd1;
   localparam logic [1:0] BaseG = 2'd2;
   localparam logic [1:0] BaseT = 2'd3;

   // Query lookup steps: self, four predecessors, four successors
   localparam int         StepW        = 4;
   localparam logic [3:0] StepSelf     = 4'd0;
   localparam logic [3:0] StepPredLast = 4'd4;
   localparam logic [3:0] StepLast     = 4'd8;

   // Context classes
   localparam logic [ClassW-1:0] ClassIsolated = 3'd0;
   localparam logic [ClassW-1:0] ClassNoPred   = 3'd1;
   localparam logic [ClassW-1:0] ClassNoSucc   = 3'd2;
   localparam logic [ClassW-1:0] ClassLinear   = 3'd3;
   localparam logic [ClassW-1:0] ClassBranch   = 3'd4;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_MARK   = 6'b000100,
      ST_QUERY  = 6'b001000,
      ST_QDRAIN = 6'b010000,
      ST_QOUT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [WordAddrW-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic                 en;
      logic [WordAddrW-1:0] addr;
      logic [WordW-1:0]     data;
   } wr_req_type;

   typedef struct packed {
      logic                 kmer_valid;
      logic [CanonOutW-1:0] canon_kmer;
      logic                 was_new;
      logic                 present;
      logic [MaskW-1:0]     pred_mask;
      logic [MaskW-1:0]     succ_mask;
      logic [CountW-1:0]    pred_count;
      logic [CountW-1:0]    succ_count;
      logic [ClassW-1:0]    context_class;
      logic [GcW-1:0]       gc_bases;
   } rsp_payload_type;

endpackage

// File: hw/rtl/ckp_req_if.sv
interface ckp_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [ckp_pkg::ByteW-1:0]   data_byte;
   logic [ckp_pkg::QueryW-1:0]  query_kmer;

   modport source (output valid, mode, data_byte, query_kmer, input ready);
   modport sink   (input valid, mode, data_byte, query_kmer, output ready);
endinterface

// File: hw/rtl/ckp_rsp_if.sv
interface ckp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           kmer_valid;
   logic [ckp_pkg::CanonOutW-1:0]  canon_kmer;
   logic                           was_new;
   logic                           present;
   logic [ckp_pkg::MaskW-1:0]      pred_mask;
   logic [ckp_pkg::MaskW-1:0]      succ_mask;
   logic [ckp_pkg::CountW-1:0]     pred_count;
   logic [ckp_pkg::CountW-1:0]     succ_count;
   logic [ckp_pkg::ClassW-1:0]     context_class;
   logic [ckp_pkg::GcW-1:0]        gc_bases;

   modport source (output valid, kmer_valid, canon_kmer, was_new, present, pred_mask,
                   succ_mask, pred_count, succ_count, context_class, gc_bases,
                   input ready);
   modport sink   (input valid, kmer_valid, canon_kmer, was_new, present, pred_mask,
                   succ_mask, pred_count, succ_count, context_class, gc_bases,
                   output ready);
endinterface

// File: hw/rtl/ckp_window.sv
module ckp_window #(
   parameter int  KMER_LEN = 11,
   localparam int KmerW    = 2 * KMER_LEN,
   localparam int RunW     = $clog2(KMER_LEN + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_valid,
   input  logic [ckp_pkg::ByteW-1:0] data_byte,
   output logic                      mark,
   output logic [KmerW-1:0]          kmer_next
);

   logic [KmerW-1:0] window_ff, window_in;
   logic [RunW-1:0]  run_ff, run_in;
   logic             in_header_ff, in_header_in;
   logic             is_base, is_space, shift;
   logic [1:0]       code;

   always_comb begin
      is_base = 1'b1;
      code    = ckp_pkg::BaseA;
      case (data_byte) inside
         ckp_pkg::ChUpA, ckp_pkg::ChLoA: code = ckp_pkg::BaseA;
         ckp_pkg::ChUpC, ckp_pkg::ChLoC: code = ckp_pkg::BaseC;
         ckp_pkg::ChUpG, ckp_pkg::ChLoG: code = ckp_pkg::BaseG;
         ckp_pkg::ChUpT, ckp_pkg::ChLoT: code = ckp_pkg::BaseT;
         default: is_base = 1'b0;
      endcase
      is_space = (data_byte == ckp_pkg::ChLf) || (data_byte == ckp_pkg::ChCr) ||
                 (data_byte == ckp_pkg::ChSpace) || (data_byte == ckp_pkg::ChTab);

      window_in    = window_ff;
      run_in       = run_ff;
      in_header_in = in_header_ff;
      shift        = 1'b0;
      if (in_header_ff) begin
         if (data_byte == ckp_pkg::ChLf) begin
            in_header_in = 1'b0;
         end
      end else if (data_byte == ckp_pkg::ChHeader) begin
         in_header_in = 1'b1;
         window_in    = '0;
         run_in       = '0;
      end else if (is_space) begin
         in_header_in = 1'b0;
      end else if (is_base) begin
         shift     = 1'b1;
         window_in = {window_ff[KmerW-3:0], code};
         if (run_ff != RunW'(KMER_LEN)) begin
            run_in = run_ff + 1'b1;
         end
      end else begin
         window_in = '0;
         run_in    = '0;
      end
      mark      = shift && (run_in == RunW'(KMER_LEN));
      kmer_next = window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         run_ff       <= '0;
         in_header_ff <= 1'b0;
      end else if (byte_valid) begin
         window_ff    <= window_in;
         run_ff       <= run_in;
         in_header_ff <= in_header_in;
      end
   end

endmodule

// File: hw/rtl/ckp_canon.sv
module ckp_canon #(
   parameter int  KMER_LEN = 11,
   localparam int KmerW    = 2 * KMER_LEN
) (
   input  logic [KmerW-1:0] kmer,
   output logic [KmerW-1:0] canon
);

   logic [KmerW-1:0] rc;

   // Reverse complement: reverse the base order, complement each 2-bit code
   always_comb begin
      rc = '0;
      for (int i = 0; i < KMER_LEN; i++) begin
         rc[2*i +: 2] = ~kmer[2*(KMER_LEN-1-i) +: 2];
      end
      canon = (rc < kmer) ? rc : kmer;
   end

endmodule

// File: hw/rtl/ckp_bitmap.sv
module ckp_bitmap (
   input  logic                       clock,
   input  ckp_pkg::rd_req_type        rd,
   input  ckp_pkg::wr_req_type        wr,
   output logic [ckp_pkg::WordW-1:0]  rd_data
);

   logic [ckp_pkg::WordW-1:0] mem_ff [ckp_pkg::Words];
   logic [ckp_pkg::WordW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/canonical_kmer_presence_table.sv
// Canonical k-mer presence table.
// req_chan carries one request per handshake: mode 0 feeds one FASTA text byte,
// mode 1 asks for the context of query_kmer. rsp_chan returns exactly one
// response per request, in request order. Handshakes complete on valid && ready.
// Text bytes walk a KMER_LEN-base window; each full window marks its canonical
// form in a 65536 x 64-bit presence bitmap held in one single-port-read memory.
// For an ingest request the bitmap word is read in the accept cycle; in ST_MARK,
// once the output register is free, it is written back and the response loaded.
// A query passes the accept cycle, nine bitmap reads (self, four predecessors,
// four successors) one per cycle through the single read port in ST_QUERY,
// ST_QDRAIN to collect the last read and ST_QOUT to load the response.
// After reset the block runs a clearing pass over all 65536 bitmap words, one
// per cycle, with req_chan.ready low; the window and header state start empty.
// The response sits in an output register; while rsp_chan stalls, the block
// still accepts the next request and holds its result until the slot frees.
module canonical_kmer_presence_table #(
   parameter int KMER_LEN = 11
) (
   input  logic          clock,
   input  logic          reset,
   ckp_req_if.sink       req_chan,
   ckp_rsp_if.source     rsp_chan
);

   localparam int KmerW  = 2 * KMER_LEN;
   localparam int GcCntW = $clog2(KMER_LEN + 1);
   localparam int AddrLo = ckp_pkg::BitSelW;
   localparam int AddrHi = ckp_pkg::BitSelW + ckp_pkg::WordAddrW - 1;

   ckp_pkg::state_type                 state_ff, state_in;
   logic [ckp_pkg::WordAddrW-1:0]      clr_addr_ff, clr_addr_in;
   logic [KmerW-1:0]                   q_ff, q_in;
   logic [GcCntW-1:0]                  gc_ff, gc_in;
   logic [ckp_pkg::StepW-1:0]          step_ff, step_in, pend_step_ff, pend_step_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic [ckp_pkg::BitSelW-1:0]        bit_sel_ff, bit_sel_in;
   logic [ckp_pkg::CanonOutW-1:0]      cf_ff, cf_in;
   logic                               mark_ff, mark_in;
   logic                               present_ff, present_in;
   logic [ckp_pkg::MaskW-1:0]          pm_ff, pm_in, sm_ff, sm_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ckp_pkg::rsp_payload_type           rsp_ff, rsp_in;

   logic                               req_accept, ingest_accept, query_accept, out_free;
   logic                               win_mark;
   logic [KmerW-1:0]                   win_kmer, cand, canon_in, canon_out;
   logic [ckp_pkg::MaxKmerW-1:0]       canon_ext, query_ext;
   logic [ckp_pkg::StepW-1:0]          step_m1, pend_m1;
   logic [1:0]                         cand_base, pend_base;
   logic [GcCntW-1:0]                  gc_sum;
   logic                               rd_bit;
   logic [ckp_pkg::CountW-1:0]         pc, sc;
   logic [ckp_pkg::ClassW-1:0]         cls;
   logic [ckp_pkg::WordW-1:0]          rd_data;
   ckp_pkg::rd_req_type                rd_req;
   ckp_pkg::wr_req_type                wr_req;

   assign req_chan.ready = (state_ff == ckp_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign ingest_accept  = req_accept && (req_chan.mode == ckp_pkg::ModeIngest);
   assign query_accept   = req_accept && (req_chan.mode == ckp_pkg::ModeQuery);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   ckp_window #(.KMER_LEN(KMER_LEN)) u_window (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (ingest_accept),
      .data_byte  (req_chan.data_byte),
      .mark       (win_mark),
      .kmer_next  (win_kmer)
   );

   // Lookup candidate: self, then predecessors by leading base, then successors
   always_comb begin
      step_m1   = step_ff - ckp_pkg::StepW'(1);
      cand_base = step_m1[1:0];
      if (step_ff == ckp_pkg::StepSelf) begin
         cand = q_ff;
      end else if (step_ff <= ckp_pkg::StepPredLast) begin
         cand = {cand_base, q_ff[KmerW-1:2]};
      end else begin
         cand = {q_ff[KmerW-3:0], cand_base};
      end
   end

   assign canon_in = (state_ff == ckp_pkg::ST_QUERY) ? cand : win_kmer;

   ckp_canon #(.KMER_LEN(KMER_LEN)) u_canon (
      .kmer  (canon_in),
      .canon (canon_out)
   );

   assign canon_ext = ckp_pkg::MaxKmerW'(canon_out);
   assign query_ext = ckp_pkg::MaxKmerW'(req_chan.query_kmer);

   always_comb begin
      gc_sum = '0;
      for (int i = 0; i < KMER_LEN; i++) begin
         gc_sum = gc_sum + GcCntW'(query_ext[2*i] ^ query_ext[2*i+1]);
      end
   end

   ckp_bitmap u_bitmap (
      .clock   (clock),
      .rd      (rd_req),
      .wr      (wr_req),
      .rd_data (rd_data)
   );

   assign rd_bit = rd_data[bit_sel_ff];

   always_comb begin
      pc = ckp_pkg::CountW'(pm_ff[0]) + ckp_pkg::CountW'(pm_ff[1]) +
           ckp_pkg::CountW'(pm_ff[2]) + ckp_pkg::CountW'(pm_ff[3]);
      sc = ckp_pkg::CountW'(sm_ff[0]) + ckp_pkg::CountW'(sm_ff[1]) +
           ckp_pkg::CountW'(sm_ff[2]) + ckp_pkg::CountW'(sm_ff[3]);
      if (pc == '0 && sc == '0) begin
         cls = ckp_pkg::ClassIsolated;
      end else if (pc == '0) begin
         cls = ckp_pkg::ClassNoPred;
      end else if (sc == '0) begin
         cls = ckp_pkg::ClassNoSucc;
      end else if (pc == ckp_pkg::CountW'(1) && sc == ckp_pkg::CountW'(1)) begin
         cls = ckp_pkg::ClassLinear;
      end else begin
         cls = ckp_pkg::ClassBranch;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      q_in         = q_ff;
      gc_in        = gc_ff;
      step_in      = step_ff;
      pend_step_in = pend_step_ff;
      rd_pend_in   = 1'b0;
      bit_sel_in   = bit_sel_ff;
      cf_in        = cf_ff;
      mark_in      = mark_ff;
      present_in   = present_ff;
      pm_in        = pm_ff;
      sm_in        = sm_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_req.en    = 1'b0;
      rd_req.addr  = canon_ext[AddrHi:AddrLo];
      wr_req.en    = 1'b0;
      wr_req.addr  = cf_ff[AddrHi:AddrLo];
      wr_req.data  = rd_data | (ckp_pkg::WordW'(1) << bit_sel_ff);

      // Fold the bit read last cycle into the query result
      pend_m1   = pend_step_ff - ckp_pkg::StepW'(1);
      pend_base = pend_m1[1:0];
      if (rd_pend_ff) begin
         if (pend_step_ff == ckp_pkg::StepSelf) begin
            present_in = rd_bit;
         end else if (pend_step_ff <= ckp_pkg::StepPredLast) begin
            pm_in[pend_base] = rd_bit;
         end else begin
            sm_in[pend_base] = rd_bit;
         end
      end

      case (state_ff)
         ckp_pkg::ST_CLEAR: begin
            wr_req.en   = 1'b1;
            wr_req.addr = clr_addr_ff;
            wr_req.data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ckp_pkg::ST_IDLE;
            end
         end
         ckp_pkg::ST_IDLE: begin
            if (ingest_accept) begin
               rd_req.en  = win_mark;
               mark_in    = win_mark;
               cf_in      = canon_ext[ckp_pkg::CanonOutW-1:0];
               bit_sel_in = canon_ext[ckp_pkg::BitSelW-1:0];
               state_in   = ckp_pkg::ST_MARK;
            end else if (query_accept) begin
               q_in       = query_ext[KmerW-1:0];
               gc_in      = gc_sum;
               step_in    = ckp_pkg::StepSelf;
               present_in = 1'b0;
               pm_in      = '0;
               sm_in      = '0;
               state_in   = ckp_pkg::ST_QUERY;
            end
         end
         ckp_pkg::ST_MARK: begin
            if (out_free) begin
               wr_req.en          = mark_ff;
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.kmer_valid  = mark_ff;
               rsp_in.canon_kmer  = mark_ff ? cf_ff : '0;
               rsp_in.was_new     = mark_ff && !rd_bit;
               state_in           = ckp_pkg::ST_IDLE;
            end
         end
         ckp_pkg::ST_QUERY: begin
            rd_req.en    = 1'b1;
            rd_pend_in   = 1'b1;
            pend_step_in = step_ff;
            bit_sel_in   = canon_ext[ckp_pkg::BitSelW-1:0];
            if (step_ff == ckp_pkg::StepSelf) begin
               cf_in = canon_ext[ckp_pkg::CanonOutW-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == ckp_pkg::StepLast) begin
               state_in = ckp_pkg::ST_QDRAIN;
            end
         end
         ckp_pkg::ST_QDRAIN: begin
            state_in = ckp_pkg::ST_QOUT;
         end
         ckp_pkg::ST_QOUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.canon_kmer     = cf_ff;
               rsp_in.present        = present_ff;
               rsp_in.pred_mask      = pm_ff;
               rsp_in.succ_mask      = sm_ff;
               rsp_in.pred_count     = pc;
               rsp_in.succ_count     = sc;
               rsp_in.context_class  = cls;
               rsp_in.gc_bases       = ckp_pkg::GcW'(gc_ff);
               state_in              = ckp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ckp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ckp_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      gc_ff        <= gc_in;
      step_ff      <= step_in;
      pend_step_ff <= pend_step_in;
      bit_sel_ff   <= bit_sel_in;
      cf_ff        <= cf_in;
      mark_ff      <= mark_in;
      present_ff   <= present_in;
      pm_ff        <= pm_in;
      sm_ff        <= sm_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kmer_valid     = rsp_ff.kmer_valid;
   assign rsp_chan.canon_kmer     = rsp_ff.canon_kmer;
   assign rsp_chan.was_new        = rsp_ff.was_new;
   assign rsp_chan.present        = rsp_ff.present;
   assign rsp_chan.pred_mask      = rsp_ff.pred_mask;
   assign rsp_chan.succ_mask      = rsp_ff.succ_mask;
   assign rsp_chan.pred_count     = rsp_ff.pred_count;
   assign rsp_chan.succ_count     = rsp_ff.succ_count;
   assign rsp_chan.context_class  = rsp_ff.context_class;
   assign rsp_chan.gc_bases       = rsp_ff.gc_bases;

   a_no_rsp_during_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ckp_pkg::ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response valid during bitmap clearing pass");

   a_drain_has_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ckp_pkg::ST_QDRAIN) |-> rd_pend_ff)
      else $error("query drain without an outstanding bitmap read");

   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      wr_req.en |-> (state_ff == ckp_pkg::ST_CLEAR || state_ff == ckp_pkg::ST_MARK))
      else $error("bitmap written outside clear or mark");

   a_new_needs_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.kmer_valid) |-> !rsp_ff.was_new)
      else $error("was_new set on a response without a marked k-mer");

endmodule
